// ===== src/c2e_pkg.sv =====
package c2e_pkg;

  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned SecsW   = 32;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;

  // register stages from input to output register
  localparam int unsigned NumStages = 5;

  localparam int unsigned DaysW = 20;
  localparam int unsigned TodW  = 17;
  localparam int unsigned CumW  = 9;

  localparam logic [YearW-1:0]  EpochYear     = 12'd2000;
  localparam logic [16:0]       SecsPerDay    = 17'd86400;
  localparam logic [TodW-1:0]   SecsPerHour   = 17'd3600;
  localparam logic [11:0]       SecsPerMinute = 12'd60;
  localparam logic [MonthW-1:0] MonthFeb      = 4'd2;

  typedef struct packed {
    logic [SecondW-1:0] second_value;
    logic [MinuteW-1:0] minute_value;
    logic [HourW-1:0]   hour_value;
    logic [DayW-1:0]    day_value;
    logic [MonthW-1:0]  month_value;
    logic [YearW-1:0]   year_value;
  } in_item_t;

  typedef logic [NumStages-1:0] stage_en_t;

  // days in the whole months before month m of a common year;
  // months past twelve count 31 days each
  function automatic logic [CumW-1:0] month_cum_days(input logic [MonthW-1:0] m);
    logic [CumW-1:0] r;
    unique case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      4'd13:   r = 9'd365;
      4'd14:   r = 9'd396;
      default: r = 9'd427;
    endcase
    return r;
  endfunction

endpackage

// ===== src/c2e_days.sv =====
module c2e_days
  import c2e_pkg::*;
(
  input  logic             clk,
  input  stage_en_t        en,
  input  in_item_t         item,
  output logic [DaysW-1:0] days
);

  // stage 1
  logic [YearW-1:0] yc;
  logic [YearW-1:0] yc_up;
  logic [YearW-1:0] s1_y;
  logic [14:0]      s1_q100_raw;
  logic [14:0]      s1_c100_raw;
  logic [CumW-1:0]  s1_cum;
  logic             s1_late;
  logic [DayW-1:0]  s1_dayoff;

  always_comb begin
    yc    = (item.year_value < EpochYear) ? '0 : item.year_value - EpochYear;
    yc_up = yc + 12'd99;
  end

  // x/100 as (x>>2)*41>>10, exact for x below 3200
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_y        <= yc;
      s1_q100_raw <= 15'(yc[YearW-1:2]) * 15'd41;
      s1_c100_raw <= 15'(yc_up[YearW-1:2]) * 15'd41;
      s1_cum      <= month_cum_days(item.month_value);
      s1_late     <= item.month_value > MonthFeb;
      s1_dayoff   <= (item.day_value == '0) ? '0 : item.day_value - 5'd1;
    end
  end

  // stage 2
  logic [YearW-1:0] s2_y;
  logic [DaysW-1:0] s2_y365;
  logic [9:0]       s2_c4;
  logic [4:0]       s2_q100;
  logic [4:0]       s2_c100;
  logic [CumW-1:0]  s2_cum;
  logic             s2_late;
  logic [DayW-1:0]  s2_dayoff;
  logic [YearW-1:0] y_p3;

  assign y_p3 = s1_y + 12'd3;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_y      <= s1_y;
      s2_y365   <= 20'(s1_y) * 20'd365;
      s2_c4     <= y_p3[YearW-1:2];
      s2_q100   <= s1_q100_raw[14:10];
      s2_c100   <= s1_c100_raw[14:10];
      s2_cum    <= s1_cum;
      s2_late   <= s1_late;
      s2_dayoff <= s1_dayoff;
    end
  end

  // stage 3: leap years before this one, leap flag of this one, total days
  logic             is_cent;
  logic             leap;
  logic [9:0]       leaps;
  logic [4:0]       c100_up;
  logic [DaysW-1:0] days_next;

  always_comb begin
    is_cent   = (12'(s2_q100) * 12'd100) == s2_y;
    leap      = (s2_y[1:0] == 2'b00) && (!is_cent || (s2_q100[1:0] == 2'b00));
    c100_up   = s2_c100 + 5'd3;
    leaps     = s2_c4 - 10'(s2_c100) + 10'(c100_up[4:2]);
    days_next = s2_y365 + 20'(leaps) + 20'(s2_cum) + 20'(leap && s2_late)
              + 20'(s2_dayoff);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      days <= days_next;
    end
  end

endmodule

// ===== src/c2e_tod.sv =====
module c2e_tod
  import c2e_pkg::*;
(
  input  logic            clk,
  input  stage_en_t       en,
  input  in_item_t        item,
  output logic [TodW-1:0] tod
);

  logic [TodW-1:0]    s1_h;
  logic [11:0]        s1_m;
  logic [SecondW-1:0] s1_s;
  logic [TodW-1:0]    s2_tod;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_h <= 17'(item.hour_value) * SecsPerHour;
      s1_m <= 12'(item.minute_value) * SecsPerMinute;
      s1_s <= item.second_value;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_tod <= s1_h + 17'(s1_m) + 17'(s1_s);
    end
  end

  // hold alongside the day count
  always_ff @(posedge clk) begin
    if (en[2]) begin
      tod <= s2_tod;
    end
  end

endmodule

// ===== src/c2e_secs.sv =====
module c2e_secs
  import c2e_pkg::*;
(
  input  logic             clk,
  input  stage_en_t        en,
  input  logic [DaysW-1:0] days,
  input  logic [TodW-1:0]  tod,
  output logic [SecsW-1:0] secs
);

  logic [36:0]      prod;
  logic [SecsW-1:0] s4_day_secs;
  logic [TodW-1:0]  s4_tod;

  assign prod = 37'(days) * 37'(SecsPerDay);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_day_secs <= prod[SecsW-1:0];
      s4_tod      <= tod;
    end
  end

  // sum wraps modulo 2^32
  always_ff @(posedge clk) begin
    if (en[4]) begin
      secs <= s4_day_secs + 32'(s4_tod);
    end
  end

endmodule

// ===== src/calendar_to_epoch_seconds_unit.sv =====
// Converts a calendar date and time to seconds since 2000-01-01 00:00:00 under
// Gregorian leap rules; years before 2000 count as 2000, day 0 counts as day 1,
// months past twelve add 31 days each, and the result wraps modulo 2^32. The
// unit is a five-stage pipeline that takes one item per clock; a stall on the
// output holds every stage that carries an item, while empty stages keep
// advancing.
module calendar_to_epoch_seconds_unit
  import c2e_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // year_value[11:0], month_value[15:12], day_value[20:16], hour_value[25:21],
  // minute_value[31:26], second_value[37:32], zero pad[39:38]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // seconds_since_2000[31:0]
  output logic [OutDataW-1:0] m_axis_tdata
);

  in_item_t         item;
  stage_en_t        en;
  stage_en_t        valid;
  logic [DaysW-1:0] days;
  logic [TodW-1:0]  tod;

  assign item = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);

  // a stage advances when it is empty or the next one advances
  always_comb begin
    en[NumStages-1] = !valid[NumStages-1] || m_axis_tready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  c2e_days u_days (
    .clk  (clk),
    .en   (en),
    .item (item),
    .days (days)
  );

  c2e_tod u_tod (
    .clk  (clk),
    .en   (en),
    .item (item),
    .tod  (tod)
  );

  c2e_secs u_secs (
    .clk  (clk),
    .en   (en),
    .days (days),
    .tod  (tod),
    .secs (m_axis_tdata)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid[NumStages-1];

endmodule

// ===== sim/calendar_to_epoch_seconds_unit_tb.sv =====
module calendar_to_epoch_seconds_unit_tb
  import c2e_pkg::*;
();

  localparam int unsigned RandPerPhase = 357;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned MaxReports   = 10;

  typedef struct {
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned hr;
    int unsigned mi;
    int unsigned se;
    bit          typed;
    int unsigned secs;
  } date_row_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  logic [SecsW-1:0] pending_secs[$];
  int unsigned      fail_count;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      hold_reqs;

  // rows with a typed-in value are the ones that follow directly from the rules
  date_row_t date_rows[] = '{
    '{0,    0,  0,  0,  0,  0,  1'b1, 32'd0},
    '{1999, 1,  1,  0,  0,  0,  1'b1, 32'd0},
    '{2000, 1,  1,  0,  0,  0,  1'b1, 32'd0},
    '{2000, 1,  1,  0,  0,  1,  1'b1, 32'd1},
    '{2000, 1,  1,  0,  1,  0,  1'b1, 32'd60},
    '{2000, 1,  1,  1,  0,  0,  1'b1, 32'd3600},
    '{2000, 1,  2,  0,  0,  0,  1'b1, 32'd86400},
    '{2000, 1,  0,  0,  0,  0,  1'b1, 32'd0},
    '{2001, 1,  1,  0,  0,  0,  1'b1, 32'd31622400},
    '{2000, 2,  1,  0,  0,  0,  1'b1, 32'd2678400},
    '{2000, 3,  1,  0,  0,  0,  1'b1, 32'd5184000},
    '{2000, 13, 1,  0,  0,  0,  1'b1, 32'd31622400},
    '{2100, 3,  1,  0,  0,  0,  1'b0, 32'd0},
    '{2400, 3,  1,  0,  0,  0,  1'b0, 32'd0},
    '{2023, 2,  31, 0,  0,  0,  1'b0, 32'd0},
    '{2000, 14, 1,  0,  0,  0,  1'b0, 32'd0},
    '{2000, 15, 31, 31, 63, 63, 1'b0, 32'd0},
    '{2000, 12, 31, 23, 59, 59, 1'b0, 32'd0},
    '{2099, 12, 31, 23, 59, 59, 1'b0, 32'd0},
    '{2136, 2,  7,  6,  28, 15, 1'b0, 32'd0},
    '{2136, 2,  7,  6,  28, 16, 1'b0, 32'd0},
    '{4095, 0,  0,  0,  0,  0,  1'b0, 32'd0},
    '{4095, 12, 31, 23, 59, 59, 1'b0, 32'd0},
    '{4095, 15, 31, 31, 63, 63, 1'b0, 32'd0}
  };

  calendar_to_epoch_seconds_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // leap years in 1..n
  function automatic int unsigned leap_days_through(input int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic logic [SecsW-1:0] seconds_since_epoch(input in_item_t it);
    int unsigned yr;
    int unsigned days;
    int unsigned m;
    bit          leap;
    yr = (it.year_value < 2000) ? 2000 : it.year_value;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    days = (yr - 2000) * 365 + leap_days_through(yr - 1) - leap_days_through(1999);
    for (m = 1; m < it.month_value; m++) begin
      case (m)
        2:           days += leap ? 29 : 28;
        4, 6, 9, 11: days += 30;
        default:     days += 31;
      endcase
    end
    if (it.day_value != 0) days += it.day_value - 1;
    return days * 86400 + it.hour_value * 3600 + it.minute_value * 60 + it.second_value;
  endfunction

  function automatic in_item_t random_date();
    in_item_t it;
    case ($urandom_range(0, 3))
      0: begin
        // raw bits, out-of-range fields included
        it.year_value   = YearW'($urandom_range(0, 4095));
        it.month_value  = MonthW'($urandom_range(0, 15));
        it.day_value    = DayW'($urandom_range(0, 31));
        it.hour_value   = HourW'($urandom_range(0, 31));
        it.minute_value = MinuteW'($urandom_range(0, 63));
        it.second_value = SecondW'($urandom_range(0, 63));
      end
      1: begin
        it.year_value   = YearW'($urandom_range(0, 4095));
        it.month_value  = MonthW'($urandom_range(1, 12));
        it.day_value    = DayW'($urandom_range(1, 31));
        it.hour_value   = HourW'($urandom_range(0, 23));
        it.minute_value = MinuteW'($urandom_range(0, 59));
        it.second_value = SecondW'($urandom_range(0, 59));
      end
      default: begin
        it.year_value   = YearW'($urandom_range(1995, 2140));
        it.month_value  = MonthW'($urandom_range(1, 12));
        it.day_value    = DayW'($urandom_range(1, 31));
        it.hour_value   = HourW'($urandom_range(0, 23));
        it.minute_value = MinuteW'($urandom_range(0, 59));
        it.second_value = SecondW'($urandom_range(0, 59));
      end
    endcase
    return it;
  endfunction

  task automatic send_date(input in_item_t it, input logic [SecsW-1:0] secs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - $bits(in_item_t)){1'b0}}, it};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_secs.push_back(secs);
  endtask

  // result side: check, then pick the next ready value
  initial begin
    logic [SecsW-1:0] want;
    int unsigned      hold_seen;
    int unsigned      hold_left;
    hold_seen = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (pending_secs.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("unexpected item: seconds_since_2000 %0d", m_axis_tdata);
        end else begin
          want = pending_secs.pop_front();
          if (m_axis_tdata !== want) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display("mismatch: seconds_since_2000 expected %0d, got %0d",
                       want, m_axis_tdata);
          end
        end
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int unsigned idle_pcts[4];
    int unsigned stall_pcts[4];
    int unsigned p;
    int unsigned i;
    in_item_t    it;
    idle_pcts  = '{0, 78, 0, 37};
    stall_pcts = '{0, 0, 78, 37};
    fail_count     = 0;
    hold_reqs      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (date_rows[r]) begin
      it.year_value   = date_rows[r].yr[YearW-1:0];
      it.month_value  = date_rows[r].mo[MonthW-1:0];
      it.day_value    = date_rows[r].dy[DayW-1:0];
      it.hour_value   = date_rows[r].hr[HourW-1:0];
      it.minute_value = date_rows[r].mi[MinuteW-1:0];
      it.second_value = date_rows[r].se[SecondW-1:0];
      send_date(it, date_rows[r].typed ? date_rows[r].secs : seconds_since_epoch(it));
    end

    for (p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      for (i = 0; i < RandPerPhase; i++) begin
        // starve the output while items keep coming so the pipeline backs up
        if ((p == 0 || p == 3) && i == 150) hold_reqs++;
        it = random_date();
        send_date(it, seconds_since_epoch(it));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_secs.size() != 0) @(posedge clk);
    repeat (NumStages + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
src/c2e_pkg.sv
src/c2e_days.sv
src/c2e_tod.sv
src/c2e_secs.sv
src/calendar_to_epoch_seconds_unit.sv
sim/calendar_to_epoch_seconds_unit_tb.sv
